// ===== rtl/imt_pkg.sv =====
// imt_pkg: shared types, codes and character constants for the irc message tokenizer
// no dependencies; imported by every rtl module of the block
package imt_pkg;

	localparam int unsigned HELD_WS_DEPTH_DEF = 16;

	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7a;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_EOL  = 1'b1;

	localparam logic [1:0] KIND_PREFIX   = 2'd0;
	localparam logic [1:0] KIND_COMMAND  = 2'd1;
	localparam logic [1:0] KIND_PARAM    = 2'd2;
	localparam logic [1:0] KIND_TRAILING = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_EMPTY    = 2'd1;
	localparam logic [1:0] ERR_NO_CMD   = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	// one output record without the end-of-run mark
	typedef struct packed {
		logic [1:0] error_code;
		logic       line_end;
		logic       param_closing;
		logic       token_end;
		logic [1:0] token_kind;
		logic [7:0] out_byte;
		logic       has_char;
	} rec_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

endpackage

// ===== rtl/imt_front.sv =====
// imt_front: accepts line items, tracks the line phase and classifies each byte
// into at most one job (held whitespace count plus closing record); uses imt_pkg
module imt_front import imt_pkg::*; #(
	parameter int unsigned HELD_WS_DEPTH = HELD_WS_DEPTH_DEF,
	localparam int unsigned CNT_W = $clog2(HELD_WS_DEPTH + 1),
	localparam int unsigned AW = $clog2(HELD_WS_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [7:0]       data_byte,
	// job queue side
	output logic             job_push,
	input  logic             job_room,
	output rec_t             job_rec,
	output logic [CNT_W-1:0] job_cnt,
	input  logic             drain_done,
	// held whitespace write port
	output logic             ws_we,
	output logic [AW-1:0]    ws_addr,
	output logic [7:0]       ws_data
);

	typedef enum logic [2:0] {
		PH_START,
		PH_PREFIX,
		PH_COMMAND,
		PH_PARAM_START,
		PH_MIDDLE,
		PH_TRAILING
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             tok_bytes_q, tb;
	logic [CNT_W-1:0] held_cnt_q, cn;
	logic             ovf_q, ovf_d;
	logic             lock_q;
	logic             push, do_feed, we;
	logic [1:0]       feed_kind;
	logic [7:0]       fb;
	logic [AW-1:0]    wa;
	logic [1:0]       eol_err;
	rec_t             rec;
	logic [CNT_W-1:0] drain;
	logic             in_fire;

	assign in_ready = !lock_q && job_room;
	assign in_fire  = in_valid && in_ready;
	assign job_push = in_fire && push;
	assign job_rec  = rec;
	assign job_cnt  = drain;
	assign ws_we    = in_fire && we;
	assign ws_addr  = wa;
	assign ws_data  = fb;

	always_comb begin
		phase_d   = phase_q;
		tb        = tok_bytes_q;
		cn        = held_cnt_q;
		ovf_d     = ovf_q;
		push      = 1'b0;
		rec       = '0;
		drain     = '0;
		do_feed   = 1'b0;
		feed_kind = KIND_PREFIX;
		we        = 1'b0;
		wa        = '0;
		fb        = data_byte;
		eol_err   = ovf_q ? ERR_OVERFLOW : ERR_NONE;
		if (cmd == CMD_EOL) begin
			push              = 1'b1;
			rec.line_end      = 1'b1;
			rec.error_code    = eol_err;
			case (phase_q)
				PH_START: begin
					rec.error_code = ERR_EMPTY;
				end
				PH_PREFIX: begin
					rec.error_code = ERR_NO_CMD;
				end
				PH_COMMAND: begin
					rec.token_kind = KIND_COMMAND;
					rec.token_end  = 1'b1;
				end
				PH_MIDDLE: begin
					rec.token_kind    = KIND_PARAM;
					rec.token_end     = 1'b1;
					rec.param_closing = 1'b1;
				end
				PH_TRAILING: begin
					rec.token_kind = KIND_TRAILING;
					rec.token_end  = 1'b1;
				end
				default: ;
			endcase
			phase_d = PH_START;
			tb      = 1'b0;
			cn      = '0;
			ovf_d   = 1'b0;
		end else begin
			case (phase_q)
				PH_PREFIX: begin
					if (data_byte == CH_SPACE) begin
						push           = 1'b1;
						rec.token_kind = KIND_PREFIX;
						rec.token_end  = 1'b1;
						phase_d        = PH_COMMAND;
						tb             = 1'b0;
						cn             = '0;
					end else begin
						do_feed   = 1'b1;
						feed_kind = KIND_PREFIX;
					end
				end
				PH_COMMAND: begin
					if (data_byte == CH_SPACE) begin
						push           = 1'b1;
						rec.token_kind = KIND_COMMAND;
						rec.token_end  = 1'b1;
						phase_d        = PH_PARAM_START;
						tb             = 1'b0;
						cn             = '0;
					end else begin
						do_feed   = 1'b1;
						feed_kind = KIND_COMMAND;
					end
				end
				PH_PARAM_START: begin
					if (data_byte == CH_COLON) begin
						phase_d = PH_TRAILING;
						tb      = 1'b0;
						cn      = '0;
					end else if (data_byte == CH_SPACE) begin
						// empty middle parameter
						push           = 1'b1;
						rec.token_kind = KIND_PARAM;
						rec.token_end  = 1'b1;
						tb             = 1'b0;
						cn             = '0;
					end else begin
						phase_d   = PH_MIDDLE;
						tb        = 1'b0;
						cn        = '0;
						do_feed   = 1'b1;
						feed_kind = KIND_PARAM;
					end
				end
				PH_MIDDLE: begin
					if (data_byte == CH_SPACE) begin
						push           = 1'b1;
						rec.token_kind = KIND_PARAM;
						rec.token_end  = 1'b1;
						phase_d        = PH_PARAM_START;
						tb             = 1'b0;
						cn             = '0;
					end else begin
						do_feed   = 1'b1;
						feed_kind = KIND_PARAM;
					end
				end
				PH_TRAILING: begin
					do_feed   = 1'b1;
					feed_kind = KIND_TRAILING;
				end
				default: begin
					tb = 1'b0;
					cn = '0;
					if (data_byte == CH_COLON) begin
						phase_d = PH_PREFIX;
					end else if (data_byte == CH_SPACE) begin
						push           = 1'b1;
						rec.token_kind = KIND_COMMAND;
						rec.token_end  = 1'b1;
						phase_d        = PH_PARAM_START;
					end else begin
						phase_d   = PH_COMMAND;
						do_feed   = 1'b1;
						feed_kind = KIND_COMMAND;
					end
				end
			endcase
			if (do_feed) begin
				if (feed_kind == KIND_COMMAND && fb inside {[CH_LC_A:CH_LC_Z]}) begin
					fb = fb - CASE_OFS;
				end
				if (is_blank(fb)) begin
					// leading blanks are dropped, inner ones held
					if (tb) begin
						if (cn < CNT_W'(HELD_WS_DEPTH)) begin
							we = 1'b1;
							wa = cn[AW-1:0];
							cn = cn + 1'b1;
						end else begin
							ovf_d = 1'b1;
						end
					end
				end else begin
					push           = 1'b1;
					rec.has_char   = 1'b1;
					rec.out_byte   = fb;
					rec.token_kind = feed_kind;
					drain          = cn;
					cn             = '0;
					tb             = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			tok_bytes_q <= 1'b0;
			held_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			lock_q      <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q     <= phase_d;
				tok_bytes_q <= tb;
				held_cnt_q  <= cn;
				ovf_q       <= ovf_d;
			end
			// hold off input until the held buffer has been read out
			if (job_push && drain != '0) begin
				lock_q <= 1'b1;
			end else if (drain_done) begin
				lock_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/imt_queue.sv =====
// imt_queue: two-entry job queue between the classifier and the record sequencer
// depends on imt_pkg only through the import convention of the project
module imt_queue import imt_pkg::*; #(
	parameter int unsigned DATA_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              room,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	logic [DATA_W-1:0] slot_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;

	assign room       = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/imt_back.sv =====
// imt_back: record sequencer; replays held whitespace from its buffer memory,
// then the job's own record, into a one-entry output register; depends on imt_pkg
module imt_back import imt_pkg::*; #(
	parameter int unsigned HELD_WS_DEPTH = HELD_WS_DEPTH_DEF,
	localparam int unsigned CNT_W = $clog2(HELD_WS_DEPTH + 1),
	localparam int unsigned AW = $clog2(HELD_WS_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	// job queue head
	input  logic             job_valid,
	input  rec_t             job_rec,
	input  logic [CNT_W-1:0] job_cnt,
	output logic             job_pop,
	output logic             drain_done,
	// held whitespace write port
	input  logic             ws_we,
	input  logic [AW-1:0]    ws_addr,
	input  logic [7:0]       ws_data,
	// record output
	output logic             out_valid,
	input  logic             out_ready,
	output rec_t             out_rec,
	output logic             out_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_HELD,
		ST_FINAL
	} state_t;

	logic [7:0]       held_mem [HELD_WS_DEPTH];
	logic [7:0]       rd_data_q;
	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	rec_t             out_rec_q;
	logic             out_last_q;
	logic             slot_free;
	rec_t             held_rec;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;

	always_comb begin
		held_rec            = '0;
		held_rec.has_char   = 1'b1;
		held_rec.out_byte   = rd_data_q;
		held_rec.token_kind = job_rec.token_kind;
	end

	always_comb begin
		job_pop    = 1'b0;
		drain_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				job_pop = job_valid && (job_cnt == '0) && slot_free;
			end
			ST_FINAL: begin
				job_pop    = slot_free;
				drain_done = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ws_we) begin
			held_mem[ws_addr] <= ws_data;
		end
		rd_data_q <= held_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_rec_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (job_cnt == '0) begin
							if (slot_free) begin
								out_valid_q <= 1'b1;
								out_rec_q   <= job_rec;
								out_last_q  <= 1'b1;
							end
						end else begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// memory read data is registered and lands in ST_HELD
					state_q <= ST_HELD;
				end
				ST_HELD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_rec_q   <= held_rec;
						out_last_q  <= 1'b0;
						idx_q       <= idx_q + 1'b1;
						state_q     <= (idx_q + 1'b1 == job_cnt) ? ST_FINAL : ST_READ;
					end
				end
				ST_FINAL: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_rec_q   <= job_rec;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/irc_message_tokenizer.sv =====
// irc_message_tokenizer: top level; classifier front, job queue, record sequencer back
// depends on imt_pkg, imt_front, imt_queue, imt_back
//
// channel  | dir | tdata                                   | tuser       | tlast
// s_axis   | in  | data_byte[7:0]                          | cmd         | -
// m_axis   | out | has_char, out_byte, token_end,          | token_kind  | last_of_run
//          |     | param_closing, line_end, error_code     |             |
//
// an ordinary token byte or token close passes from the queue straight to the output
// register; a byte that releases n held whitespace characters makes the back sequencer
// start the drain, then do a memory read and an output load for each held character,
// then load the closing record, and input is held off until that drain ends.
// the front keeps working while fewer than two jobs wait in the queue.
// reset clears all control state; the held whitespace buffer needs no clearing.
// a stalled m_axis holds the output register and backs up through the queue to s_axis.
module irc_message_tokenizer import imt_pkg::*; #(
	parameter int unsigned HELD_WS_DEPTH = HELD_WS_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] has_char, [8:1] out_byte, [9] token_end, [10] param_closing,
	// [11] line_end, [13:12] error_code, [15:14] zero
	output logic [15:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [1:0] token_kind
	output logic        m_axis_tlast   // last_of_run
);

	localparam int unsigned CNT_W = $clog2(HELD_WS_DEPTH + 1);
	localparam int unsigned AW = $clog2(HELD_WS_DEPTH);
	localparam int unsigned JOB_W = $bits(rec_t) + CNT_W;

	logic             f_push, q_room, q_valid, q_pop, drain_done;
	rec_t             f_rec, h_rec, o_rec;
	logic [CNT_W-1:0] f_cnt, h_cnt;
	logic [JOB_W-1:0] q_head;
	logic             ws_we;
	logic [AW-1:0]    ws_addr;
	logic [7:0]       ws_data;

	imt_front #(.HELD_WS_DEPTH(HELD_WS_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.cmd        (s_axis_tuser),
		.data_byte  (s_axis_tdata),
		.job_push   (f_push),
		.job_room   (q_room),
		.job_rec    (f_rec),
		.job_cnt    (f_cnt),
		.drain_done (drain_done),
		.ws_we      (ws_we),
		.ws_addr    (ws_addr),
		.ws_data    (ws_data)
	);

	imt_queue #(.DATA_W(JOB_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_push),
		.room       (q_room),
		.push_data  ({f_cnt, f_rec}),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	assign h_rec = q_head[$bits(rec_t)-1:0];
	assign h_cnt = q_head[JOB_W-1:$bits(rec_t)];

	imt_back #(.HELD_WS_DEPTH(HELD_WS_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_valid),
		.job_rec    (h_rec),
		.job_cnt    (h_cnt),
		.job_pop    (q_pop),
		.drain_done (drain_done),
		.ws_we      (ws_we),
		.ws_addr    (ws_addr),
		.ws_data    (ws_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_rec    (o_rec),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, o_rec.error_code, o_rec.line_end, o_rec.param_closing,
		o_rec.token_end, o_rec.out_byte, o_rec.has_char};
	assign m_axis_tuser = o_rec.token_kind;

endmodule
